// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the boundary enforce rtl
// no dependencies; taken in by `include where checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define PBE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define PBE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pbe_pkg.sv =====
// shared types, constants and helpers for the particle boundary enforce unit
// no dependencies; used by pbe_axis_lane, pbe_merge and the top level
`timescale 1ns / 1ps

package pbe_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int NUM_AXES        = 3;
    localparam int SUM_WIDTH       = COORD_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int MODE_WIDTH      = 3;
    localparam int TDATA_WIDTH     = ((2 * NUM_AXES * COORD_WIDTH + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [MODE_WIDTH-1:0]         mode_code_t;

    // edge modes; codes above clamp behave as none
    localparam mode_code_t MODE_NONE   = 3'd0;
    localparam mode_code_t MODE_KILL   = 3'd1;
    localparam mode_code_t MODE_WRAP   = 3'd2;
    localparam mode_code_t MODE_BOUNCE = 3'd3;
    localparam mode_code_t MODE_CLAMP  = 3'd4;

    // configuration register indexes
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    localparam cfg_index_t REG_BOX_MIN_X = 3'd0;
    localparam cfg_index_t REG_BOX_MIN_Y = 3'd1;
    localparam cfg_index_t REG_BOX_MIN_Z = 3'd2;
    localparam cfg_index_t REG_BOX_MAX_X = 3'd3;
    localparam cfg_index_t REG_BOX_MAX_Y = 3'd4;
    localparam cfg_index_t REG_BOX_MAX_Z = 3'd5;
    localparam cfg_index_t REG_EDGE_MODE = 3'd6;

    localparam coord_t BOX_MAX_RESET = coord_t'(65536);
    localparam coord_t BOX_MIN_RESET = -BOX_MAX_RESET;
    localparam coord_t COORD_MAX     = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN     = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // what one axis lane hands to the merge stage
    typedef struct packed {
        coord_t pos;
        coord_t prev;
        logic   hit;
    } lane_res_t;

    // clip a widened sum back into the coordinate range
    function automatic coord_t sat_coord(input sum_t v);
        logic [2:0] top;
        top = v[SUM_WIDTH-1:COORD_WIDTH-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[SUM_WIDTH-1]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

endpackage

// ===== hw/rtl/pbe_axis_lane.sv =====
// one axis lane: box test and edge mode arithmetic for a single coordinate
// depends on pbe_pkg
`timescale 1ns / 1ps

module pbe_axis_lane (
    input  logic                aclk,
    input  logic                load,
    input  logic                alive,
    input  pbe_pkg::coord_t     pos,
    input  pbe_pkg::coord_t     prev,
    input  pbe_pkg::coord_t     box_lo,
    input  pbe_pkg::coord_t     box_hi,
    input  pbe_pkg::mode_code_t mode,
    output pbe_pkg::lane_res_t  res
);

    logic            below;
    logic            above;
    pbe_pkg::coord_t face;
    pbe_pkg::sum_t   wrap_sum;
    pbe_pkg::sum_t   mir_sum;

    logic            hit_reg;
    pbe_pkg::coord_t pos_reg;
    pbe_pkg::coord_t prev_reg;
    pbe_pkg::coord_t face_reg;
    pbe_pkg::sum_t   wrap_sum_reg;
    pbe_pkg::sum_t   mir_sum_reg;

    // first half: compares and widened sums
    always_comb begin
        below = (pos < box_lo);
        above = !below && (pos > box_hi);
        face  = below ? box_lo : box_hi;
        if (below) begin
            wrap_sum = pbe_pkg::sum_t'(box_hi) - pbe_pkg::sum_t'(box_lo)
                     + pbe_pkg::sum_t'(pos);
        end else begin
            wrap_sum = pbe_pkg::sum_t'(box_lo) - pbe_pkg::sum_t'(box_hi)
                     + pbe_pkg::sum_t'(pos);
        end
        mir_sum = (pbe_pkg::sum_t'(face) <<< 1) - pbe_pkg::sum_t'(prev);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hit_reg      <= alive && (below || above);
            pos_reg      <= pos;
            prev_reg     <= prev;
            face_reg     <= face;
            wrap_sum_reg <= wrap_sum;
            mir_sum_reg  <= mir_sum;
        end
    end

    // second half: saturate and pick by mode
    always_comb begin
        res.hit  = hit_reg;
        res.pos  = pos_reg;
        res.prev = prev_reg;
        if (hit_reg) begin
            unique case (mode)
                pbe_pkg::MODE_WRAP: begin
                    res.pos  = pbe_pkg::sat_coord(wrap_sum_reg);
                    res.prev = pbe_pkg::sat_coord(wrap_sum_reg);
                end
                pbe_pkg::MODE_BOUNCE: begin
                    res.pos  = face_reg;
                    res.prev = pbe_pkg::sat_coord(mir_sum_reg);
                end
                pbe_pkg::MODE_CLAMP: begin
                    res.pos  = face_reg;
                    res.prev = face_reg;
                end
                default: begin
                    res.pos  = pos_reg;
                    res.prev = prev_reg;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/pbe_merge.sv =====
// merge stage: folds the lane results into one particle and holds the output register
// depends on pbe_pkg
`timescale 1ns / 1ps

module pbe_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_alive,
    input  pbe_pkg::mode_code_t mode,
    input  pbe_pkg::lane_res_t  lane_res [pbe_pkg::NUM_AXES],
    output logic                out_valid,
    input  logic                out_ready,
    output pbe_pkg::coord_t     out_pos  [pbe_pkg::NUM_AXES],
    output pbe_pkg::coord_t     out_prev [pbe_pkg::NUM_AXES],
    output logic                out_alive
);

    logic            valid_reg;
    logic            valid_next;
    logic            alive_reg;
    logic            alive_next;
    logic            any_hit;
    logic            load;
    pbe_pkg::coord_t pos_reg  [pbe_pkg::NUM_AXES];
    pbe_pkg::coord_t prev_reg [pbe_pkg::NUM_AXES];

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        any_hit = 1'b0;
        for (int a = 0; a < pbe_pkg::NUM_AXES; a++) begin
            any_hit = any_hit || lane_res[a].hit;
        end
        alive_next = in_alive && !((mode == pbe_pkg::MODE_KILL) && any_hit);
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            alive_reg <= alive_next;
            for (int a = 0; a < pbe_pkg::NUM_AXES; a++) begin
                pos_reg[a]  <= lane_res[a].pos;
                prev_reg[a] <= lane_res[a].prev;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_alive = alive_reg;
    assign out_pos   = pos_reg;
    assign out_prev  = prev_reg;

endmodule

// ===== hw/rtl/particle_boundary_enforce_unit.sv =====
// particle boundary enforce unit: accepts one verlet particle (current and previous
// position on three axes, signed q16.16, plus an alive flag) per transaction and
// returns exactly one result per particle, in order. each axis is tested against the
// configured box (bounds inclusive, the below-min test wins on an inverted box) and
// the edge mode is applied: none passes through, kill clears alive, wrap carries the
// overshoot to the opposite face with previous set to current, bounce pins to the
// face and mirrors previous about it, clamp pins both. results that leave the
// coordinate range saturate; dead particles pass unchanged. one particle enters per
// cycle while the output is not stalled, and its result passes one register stage
// inside the three axis lanes (compares and sums), then the output register of the
// merge stage. the box and mode registers are written over the cfg channel, which is
// always ready, and must only be written while no particle is in flight.
// depends on pbe_pkg, pbe_axis_lane, pbe_merge and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module particle_boundary_enforce_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // particle in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pos_x, pos_y, pos_z, prev_x, prev_y, prev_z
    input  logic [pbe_pkg::TDATA_WIDTH-1:0]       s_tdata,
    // alive
    input  logic [0:0]                            s_tuser,

    // particle out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_prev_x, new_prev_y, new_prev_z
    output logic [pbe_pkg::TDATA_WIDTH-1:0]       m_tdata,
    // alive_out
    output logic [0:0]                            m_tuser,

    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pbe_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [pbe_pkg::COORD_WIDTH-1:0]       cfg_data
);

    localparam int CW = pbe_pkg::COORD_WIDTH;
    localparam int NA = pbe_pkg::NUM_AXES;

    // configuration registers
    pbe_pkg::coord_t     box_lo_reg [NA];
    pbe_pkg::coord_t     box_hi_reg [NA];
    pbe_pkg::mode_code_t mode_reg;

    // stage one control
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_alive_reg;
    logic merge_ready;
    logic in_xact;

    pbe_pkg::lane_res_t lane_res [NA];
    pbe_pkg::coord_t    out_pos  [NA];
    pbe_pkg::coord_t    out_prev [NA];
    logic               out_alive;

    // config channel never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NA; a++) begin
                box_lo_reg[a] <= pbe_pkg::BOX_MIN_RESET;
                box_hi_reg[a] <= pbe_pkg::BOX_MAX_RESET;
            end
            mode_reg <= pbe_pkg::MODE_NONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pbe_pkg::REG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                pbe_pkg::REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                pbe_pkg::REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                pbe_pkg::REG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                pbe_pkg::REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                pbe_pkg::REG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                pbe_pkg::REG_EDGE_MODE: mode_reg      <= cfg_data[pbe_pkg::MODE_WIDTH-1:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // stage one accepts whenever it is empty or hands its particle on
    assign s_tready      = !s1_valid_reg || merge_ready;
    assign in_xact       = s_tvalid && s_tready;
    assign s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xact) begin
            s1_alive_reg <= s_tuser[0];
        end
    end

    // one lane per axis, each with its own compare and sum stage
    for (genvar a = 0; a < NA; a++) begin : g_lane
        pbe_axis_lane u_lane (
            .aclk   (aclk),
            .load   (in_xact),
            .alive  (s_tuser[0]),
            .pos    (s_tdata[a*CW +: CW]),
            .prev   (s_tdata[(NA+a)*CW +: CW]),
            .box_lo (box_lo_reg[a]),
            .box_hi (box_hi_reg[a]),
            .mode   (mode_reg),
            .res    (lane_res[a])
        );
    end

    // merge the lanes into one particle and register it for the output side
    pbe_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (merge_ready),
        .in_alive  (s1_alive_reg),
        .mode      (mode_reg),
        .lane_res  (lane_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pos   (out_pos),
        .out_prev  (out_prev),
        .out_alive (out_alive)
    );

    assign m_tdata = pbe_pkg::TDATA_WIDTH'({out_prev[2], out_prev[1], out_prev[0],
                                            out_pos[2], out_pos[1], out_pos[0]});
    assign m_tuser = out_alive;

    // checks
    `PBE_ASSERT_ALWAYS(a_out_empty_after_reset, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `PBE_ASSERT(a_in_lands_in_s1, aclk, aresetn, (s_tvalid && s_tready) |=> s1_valid_reg, "accepted particle lost before stage one")
    `PBE_ASSERT(a_full_pipe_stalls, aclk, aresetn, (s1_valid_reg && m_tvalid && !m_tready) |-> !s_tready, "input taken while pipeline full and stalled")

endmodule
